// ===== sv/bpdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpdp_pkg;

	localparam int MAX_BYTES  = 65536;
	localparam int MAX_PLANES = 8;
	localparam int WORD_W     = 64;
	localparam int BYTES_N    = WORD_W / 8;
	localparam int NB_W       = 4;
	localparam int CNT_W      = 7;
	localparam int ADD_W      = CNT_W + MAX_PLANES - 1;
	localparam int BYTES_W    = $clog2(MAX_BYTES + 1);
	localparam int DOT_W      = 28;
	localparam int ONES_W     = 20;
	localparam int DOT_OUT_W  = 27;
	localparam int ONES_OUT_W = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam longint DOT_CAP_RAW  = longint'(MAX_BYTES) * 8 * ((longint'(1) << MAX_PLANES) - 1);
	localparam longint DOT_FLD_MAX  = (longint'(1) << DOT_OUT_W) - 1;
	localparam longint ONES_CAP_RAW = longint'(MAX_BYTES) * 8;
	localparam longint ONES_FLD_MAX = (longint'(1) << ONES_OUT_W) - 1;

	localparam logic [DOT_W-1:0] DOT_CAP =
		DOT_W'((DOT_CAP_RAW > DOT_FLD_MAX) ? DOT_FLD_MAX : DOT_CAP_RAW);
	localparam logic [ONES_W-1:0] ONES_CAP =
		ONES_W'((ONES_CAP_RAW > ONES_FLD_MAX) ? ONES_FLD_MAX : ONES_CAP_RAW);
	localparam logic [BYTES_W-1:0] BYTES_LIMIT = BYTES_W'(MAX_BYTES);

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PLANES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE  = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t                    data;
		word_t [MAX_PLANES-1:0]   plane;
		logic  [NB_W-1:0]         nbytes;
		logic                     last;
	} bpdp_word_t;

	typedef struct packed {
		logic                valid;
		logic [ADD_W-1:0]    add;
		logic [CNT_W-1:0]    ones;
		logic [NB_W-1:0]     nbytes;
		logic                last;
	} bpdp_cnt_t;

	function automatic logic [3:0] pop8(input logic [7:0] x);
		logic [3:0] c;
		c = '0;
		for (int b = 0; b < 8; b++) begin
			c = c + 4'(x[b]);
		end
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] pop64(input word_t x);
		logic [CNT_W-1:0] s;
		s = '0;
		for (int i = 0; i < BYTES_N; i++) begin
			s = s + CNT_W'(pop8(x[8*i +: 8]));
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== sv/bpdp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bpdp_in_if;
	logic                   valid;
	logic                   ready;
	bpdp_pkg::word_t        data_word;
	bpdp_pkg::word_t        query_plane_0;
	bpdp_pkg::word_t        query_plane_1;
	bpdp_pkg::word_t        query_plane_2;
	bpdp_pkg::word_t        query_plane_3;
	bpdp_pkg::word_t        query_plane_4;
	bpdp_pkg::word_t        query_plane_5;
	bpdp_pkg::word_t        query_plane_6;
	bpdp_pkg::word_t        query_plane_7;
	logic [bpdp_pkg::NB_W-1:0] valid_bytes;
	logic                   last_word;

	modport source (output valid, data_word, query_plane_0, query_plane_1, query_plane_2,
		query_plane_3, query_plane_4, query_plane_5, query_plane_6, query_plane_7,
		valid_bytes, last_word, input ready);
	modport sink (input valid, data_word, query_plane_0, query_plane_1, query_plane_2,
		query_plane_3, query_plane_4, query_plane_5, query_plane_6, query_plane_7,
		valid_bytes, last_word, output ready);
endinterface

interface bpdp_out_if;
	logic                             valid;
	logic                             ready;
	logic [bpdp_pkg::DOT_OUT_W-1:0]   weighted_sum;
	logic [bpdp_pkg::ONES_OUT_W-1:0]  data_popcount;
	logic                             too_long;

	modport source (output valid, weighted_sum, data_popcount, too_long, input ready);
	modport sink (input valid, weighted_sum, data_popcount, too_long, output ready);
endinterface
`default_nettype wire

// ===== sv/bpdp_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpdp_count (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic [3:0]            active_planes,
	input  wire logic                  combine_mode,
	input  wire logic                  valid_s1,
	input  wire bpdp_pkg::bpdp_word_t  word_s1,
	output bpdp_pkg::bpdp_cnt_t        cnt_s3
);

	bpdp_pkg::word_t                                      mask;
	logic [bpdp_pkg::MAX_PLANES-1:0][bpdp_pkg::CNT_W-1:0] cnt;
	logic [bpdp_pkg::MAX_PLANES-1:0][bpdp_pkg::CNT_W-1:0] cnt_s2;
	logic [bpdp_pkg::CNT_W-1:0]                           ones_s2;
	logic [bpdp_pkg::NB_W-1:0]                            nbytes_s2;
	logic                                                 last_s2;
	logic                                                 valid_s2;
	logic [bpdp_pkg::ADD_W-1:0]                           add;

	always_comb begin
		for (int b = 0; b < bpdp_pkg::BYTES_N; b++) begin
			mask[8*b +: 8] = {8{bpdp_pkg::NB_W'(b) < word_s1.nbytes}};
		end
		for (int j = 0; j < bpdp_pkg::MAX_PLANES; j++) begin
			if (active_planes > 4'(j)) begin
				cnt[j] = bpdp_pkg::pop64((combine_mode ?
					(word_s1.plane[j] ^ word_s1.data) :
					(word_s1.plane[j] & word_s1.data)) & mask);
			end else begin
				cnt[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s2    <= cnt;
			ones_s2   <= bpdp_pkg::pop64(word_s1.data & mask);
			nbytes_s2 <= word_s1.nbytes;
			last_s2   <= word_s1.last;
		end
	end

	// weight plane j by 2^j
	always_comb begin
		add = '0;
		for (int j = 0; j < bpdp_pkg::MAX_PLANES; j++) begin
			add = add + (bpdp_pkg::ADD_W'(cnt_s2[j]) << j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s3 <= '0;
		end else if (en) begin
			cnt_s3.valid  <= valid_s2;
			cnt_s3.add    <= add;
			cnt_s3.ones   <= ones_s2;
			cnt_s3.nbytes <= nbytes_s2;
			cnt_s3.last   <= last_s2;
		end
	end

endmodule
`default_nettype wire

// ===== sv/bpdp_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpdp_accum (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire bpdp_pkg::bpdp_cnt_t            cnt_s3,
	output logic                                res_valid_q,
	output logic [bpdp_pkg::DOT_OUT_W-1:0]      res_dot_q,
	output logic [bpdp_pkg::ONES_OUT_W-1:0]     res_ones_q,
	output logic                                res_long_q
);

	logic [bpdp_pkg::DOT_W-1:0]   dot_q;
	logic [bpdp_pkg::ONES_W-1:0]  ones_q;
	logic [bpdp_pkg::BYTES_W-1:0] bytes_q;
	logic                         ovf_q;

	logic [bpdp_pkg::DOT_W:0]     dot_sum;
	logic [bpdp_pkg::ONES_W:0]    ones_sum;
	logic [bpdp_pkg::BYTES_W:0]   bytes_sum;
	logic [bpdp_pkg::DOT_W-1:0]   dot_nx;
	logic [bpdp_pkg::ONES_W-1:0]  ones_nx;
	logic [bpdp_pkg::BYTES_W-1:0] bytes_nx;
	logic                         ovf_nx;

	always_comb begin
		dot_sum   = {1'b0, dot_q} + (bpdp_pkg::DOT_W + 1)'(cnt_s3.add);
		ones_sum  = {1'b0, ones_q} + (bpdp_pkg::ONES_W + 1)'(cnt_s3.ones);
		bytes_sum = {1'b0, bytes_q} + (bpdp_pkg::BYTES_W + 1)'(cnt_s3.nbytes);
		dot_nx    = dot_q;
		ones_nx   = ones_q;
		bytes_nx  = bytes_q;
		ovf_nx    = ovf_q;
		if (!ovf_q) begin
			if (bytes_sum > {1'b0, bpdp_pkg::BYTES_LIMIT}) begin
				ovf_nx   = 1'b1;
				dot_nx   = bpdp_pkg::DOT_CAP;
				ones_nx  = bpdp_pkg::ONES_CAP;
				bytes_nx = bpdp_pkg::BYTES_LIMIT;
			end else begin
				dot_nx   = (dot_sum > {1'b0, bpdp_pkg::DOT_CAP}) ?
					bpdp_pkg::DOT_CAP : dot_sum[bpdp_pkg::DOT_W-1:0];
				ones_nx  = (ones_sum > {1'b0, bpdp_pkg::ONES_CAP}) ?
					bpdp_pkg::ONES_CAP : ones_sum[bpdp_pkg::ONES_W-1:0];
				bytes_nx = bytes_sum[bpdp_pkg::BYTES_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= '0;
			ones_q      <= '0;
			bytes_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= cnt_s3.valid && cnt_s3.last;
			if (cnt_s3.valid) begin
				if (cnt_s3.last) begin
					dot_q   <= '0;
					ones_q  <= '0;
					bytes_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					dot_q   <= dot_nx;
					ones_q  <= ones_nx;
					bytes_q <= bytes_nx;
					ovf_q   <= ovf_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && cnt_s3.valid && cnt_s3.last) begin
			res_dot_q  <= dot_nx[bpdp_pkg::DOT_OUT_W-1:0];
			res_ones_q <= ones_nx[bpdp_pkg::ONES_OUT_W-1:0];
			res_long_q <= ovf_nx;
		end
	end

endmodule
`default_nettype wire

// ===== sv/bitplane_popcount_dot_product_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Results: the totals of a vector land in the output register once its last word has run the pipe.
// Throughput: one word per cycle; the pipe is input register, popcount, plane weighting and the
// accumulator with its output register, and the whole pipe holds while a result waits unread.
// Reset: asynchronous, clears totals, pipe valids and the output valid; active_planes 1, combine_mode 0.
module bitplane_popcount_dot_product_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bpdp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bpdp_pkg::CFG_DATA_W-1:0]     cfg_data,
	bpdp_in_if.sink                                  item,
	bpdp_out_if.source                               result
);

	logic                  en;
	logic [3:0]            active_planes_q;
	logic                  combine_mode_q;
	logic                  valid_s1;
	bpdp_pkg::bpdp_word_t  word_s1;
	bpdp_pkg::bpdp_cnt_t   cnt_s3;
	logic                  res_valid_q;

	assign en         = !res_valid_q || result.ready;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_planes_q <= 4'd1;
			combine_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpdp_pkg::CFG_ACTIVE_PLANES: active_planes_q <= cfg_data[3:0];
				bpdp_pkg::CFG_COMBINE_MODE:  combine_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && item.valid) begin
			word_s1.data     <= item.data_word;
			word_s1.plane[0] <= item.query_plane_0;
			word_s1.plane[1] <= item.query_plane_1;
			word_s1.plane[2] <= item.query_plane_2;
			word_s1.plane[3] <= item.query_plane_3;
			word_s1.plane[4] <= item.query_plane_4;
			word_s1.plane[5] <= item.query_plane_5;
			word_s1.plane[6] <= item.query_plane_6;
			word_s1.plane[7] <= item.query_plane_7;
			word_s1.nbytes   <= (item.valid_bytes > bpdp_pkg::NB_W'(bpdp_pkg::BYTES_N)) ?
				bpdp_pkg::NB_W'(bpdp_pkg::BYTES_N) : item.valid_bytes;
			word_s1.last     <= item.last_word;
		end
	end

	bpdp_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.active_planes (active_planes_q),
		.combine_mode  (combine_mode_q),
		.valid_s1      (valid_s1),
		.word_s1       (word_s1),
		.cnt_s3        (cnt_s3)
	);

	bpdp_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cnt_s3      (cnt_s3),
		.res_valid_q (res_valid_q),
		.res_dot_q   (result.weighted_sum),
		.res_ones_q  (result.data_popcount),
		.res_long_q  (result.too_long)
	);

	assign result.valid = res_valid_q;

endmodule
`default_nettype wire

// ===== tb/bitplane_popcount_dot_product_core_tb.sv =====
`timescale 1ns / 1ps
module bitplane_popcount_dot_product_core_tb;

	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 225;
	localparam longint CYCLE_LIMIT = 600000;

	localparam longint DOT_SPAN = longint'(bpdp_pkg::MAX_BYTES) * 8 *
		((longint'(1) << bpdp_pkg::MAX_PLANES) - 1);
	localparam longint DOT_TOP = (longint'(1) << bpdp_pkg::DOT_OUT_W) - 1;
	localparam longint DOT_CEIL = (DOT_SPAN > DOT_TOP) ? DOT_TOP : DOT_SPAN;
	localparam longint ONES_SPAN = longint'(bpdp_pkg::MAX_BYTES) * 8;
	localparam longint ONES_TOP = (longint'(1) << bpdp_pkg::ONES_OUT_W) - 1;
	localparam longint ONES_CEIL = (ONES_SPAN > ONES_TOP) ? ONES_TOP : ONES_SPAN;

	typedef struct packed {
		logic [63:0]      data;
		logic [7:0][63:0] plane;
		logic [3:0]       nbytes;
		logic             last;
	} code_word_t;

	typedef struct packed {
		logic [bpdp_pkg::DOT_OUT_W-1:0]  dot;
		logic [bpdp_pkg::ONES_OUT_W-1:0] ones;
		logic                            too_long;
	} totals_t;

	function automatic int unsigned ones_in(input logic [63:0] x);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 64; i++) n += x[i];
		return n;
	endfunction

	class popcount_dot_tracker;
		int unsigned planes_reg;
		bit          xor_mode;
		longint      dot_sum;
		longint      ones_sum;
		longint      bytes_taken;
		bit          overflowed;
		totals_t     totals_due[$];
		int unsigned mismatches;

		function new();
			planes_reg = 1;
			xor_mode = 0;
			dot_sum = 0;
			ones_sum = 0;
			bytes_taken = 0;
			overflowed = 0;
			mismatches = 0;
		endfunction

		function void set_reg(input logic [bpdp_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpdp_pkg::CFG_DATA_W-1:0] value);
			if (idx == bpdp_pkg::CFG_ACTIVE_PLANES) begin
				planes_reg = value;
			end else if (idx == bpdp_pkg::CFG_COMBINE_MODE) begin
				xor_mode = value[0];
			end
		endfunction

		function void take_word(input code_word_t w);
			int unsigned nb;
			int unsigned np;
			logic [63:0] keep;
			logic [63:0] mixed;
			longint      gain;
			totals_t     t;
			nb = (w.nbytes > 8) ? 8 : w.nbytes;
			np = (planes_reg > bpdp_pkg::MAX_PLANES) ? bpdp_pkg::MAX_PLANES : planes_reg;
			keep = (nb == 8) ? '1 : ((64'd1 << (nb * 8)) - 64'd1);
			if (!overflowed) begin
				if (bytes_taken + nb > bpdp_pkg::MAX_BYTES) begin
					overflowed = 1;
					dot_sum = DOT_CEIL;
					ones_sum = ONES_CEIL;
					bytes_taken = bpdp_pkg::MAX_BYTES;
				end else begin
					gain = 0;
					for (int j = 0; j < np; j++) begin
						mixed = xor_mode ? (w.plane[j] ^ w.data) : (w.plane[j] & w.data);
						gain += longint'(ones_in(mixed & keep)) << j;
					end
					dot_sum = (dot_sum + gain > DOT_CEIL) ? DOT_CEIL : dot_sum + gain;
					ones_sum += ones_in(w.data & keep);
					if (ones_sum > ONES_CEIL) ones_sum = ONES_CEIL;
					bytes_taken += nb;
				end
			end
			if (w.last) begin
				t.dot = dot_sum[bpdp_pkg::DOT_OUT_W-1:0];
				t.ones = ones_sum[bpdp_pkg::ONES_OUT_W-1:0];
				t.too_long = overflowed;
				totals_due.push_back(t);
				dot_sum = 0;
				ones_sum = 0;
				bytes_taken = 0;
				overflowed = 0;
			end
		endfunction

		function void match_totals(input totals_t got);
			totals_t want;
			if (totals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: dot %0d ones %0d too_long %0b",
						got.dot, got.ones, got.too_long);
				return;
			end
			want = totals_due.pop_front();
			if (got.dot !== want.dot || got.ones !== want.ones || got.too_long !== want.too_long)
			begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: dot %0d/%0d ones %0d/%0d too_long %0b/%0b (exp/got)",
						want.dot, got.dot, want.ones, got.ones, want.too_long, got.too_long);
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bpdp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bpdp_pkg::CFG_DATA_W-1:0] cfg_data;
	bpdp_in_if                       word_in ();
	bpdp_out_if                      total_out ();

	popcount_dot_tracker tracker = new();
	bit          quiet = 0;
	bit          hold_due = 0;
	bit          hold_taken = 0;
	longint      cycles = 0;
	int unsigned words_sent = 0;

	bitplane_popcount_dot_product_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(word_in),
		.result(total_out)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		code_word_t w;
		if (arst_n && word_in.valid && word_in.ready) begin
			w.data = word_in.data_word;
			w.plane[0] = word_in.query_plane_0;
			w.plane[1] = word_in.query_plane_1;
			w.plane[2] = word_in.query_plane_2;
			w.plane[3] = word_in.query_plane_3;
			w.plane[4] = word_in.query_plane_4;
			w.plane[5] = word_in.query_plane_5;
			w.plane[6] = word_in.query_plane_6;
			w.plane[7] = word_in.query_plane_7;
			w.nbytes = word_in.valid_bytes;
			w.last = word_in.last_word;
			tracker.take_word(w);
		end
	end

	always @(posedge clk) begin
		totals_t got;
		if (arst_n && total_out.valid && total_out.ready) begin
			got.dot = total_out.weighted_sum;
			got.ones = total_out.data_popcount;
			got.too_long = total_out.too_long;
			tracker.match_totals(got);
		end
	end

	// result side: random stalls, one long hold-off so the pipe backs up
	initial begin
		total_out.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_due && !hold_taken) begin
				total_out.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
				hold_taken = 1;
				total_out.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < 4) begin
				total_out.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				total_out.ready <= 1'b1;
			end else begin
				total_out.ready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic code_word_t make_word(input logic [63:0] d, input logic [63:0] p,
		input logic [3:0] nb, input bit last);
		code_word_t w;
		w.data = d;
		for (int j = 0; j < 8; j++) w.plane[j] = p;
		w.nbytes = nb;
		w.last = last;
		return w;
	endfunction

	task automatic send_word(input code_word_t w);
		if (!quiet && $urandom_range(0, 99) < 4) begin
			word_in.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		word_in.valid <= 1'b1;
		word_in.data_word <= w.data;
		word_in.query_plane_0 <= w.plane[0];
		word_in.query_plane_1 <= w.plane[1];
		word_in.query_plane_2 <= w.plane[2];
		word_in.query_plane_3 <= w.plane[3];
		word_in.query_plane_4 <= w.plane[4];
		word_in.query_plane_5 <= w.plane[5];
		word_in.query_plane_6 <= w.plane[6];
		word_in.query_plane_7 <= w.plane[7];
		word_in.valid_bytes <= w.nbytes;
		word_in.last_word <= w.last;
		@(posedge clk);
		while (!word_in.ready) @(posedge clk);
		words_sent++;
	endtask

	// ragged vectors take any valid_bytes on any word; the rest are full but the last
	task automatic send_vector(input int unsigned n, input bit ragged);
		code_word_t w;
		for (int unsigned k = 0; k < n; k++) begin
			w.data = rand64();
			for (int j = 0; j < 8; j++) w.plane[j] = rand64();
			w.last = (k == n - 1);
			if (ragged) begin
				w.nbytes = 4'($urandom_range(0, 15));
			end else if (w.last) begin
				w.nbytes = 4'($urandom_range(1, 8));
			end else begin
				w.nbytes = 4'd8;
			end
			send_word(w);
		end
	endtask

	task automatic settle();
		word_in.valid <= 1'b0;
		while (tracker.totals_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bpdp_pkg::CFG_IDX_W-1:0] idx,
		input logic [bpdp_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	initial begin
		int unsigned plane_pick [8];
		bit          mode_pick [8];
		int unsigned start;
		plane_pick = '{1, 8, 0, 15, 3, 8, 6, 2};
		mode_pick = '{0, 1, 1, 0, 1, 0, 0, 1};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		word_in.valid = 1'b0;
		word_in.data_word = '0;
		word_in.query_plane_0 = '0;
		word_in.query_plane_1 = '0;
		word_in.query_plane_2 = '0;
		word_in.query_plane_3 = '0;
		word_in.query_plane_4 = '0;
		word_in.query_plane_5 = '0;
		word_in.query_plane_6 = '0;
		word_in.query_plane_7 = '0;
		word_in.valid_bytes = '0;
		word_in.last_word = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one plane, AND
		send_word(make_word('1, '1, 4'd8, 1));
		send_word(make_word(rand64(), rand64(), 4'd0, 1));
		send_word(make_word(rand64(), rand64(), 4'd15, 1));
		send_word(make_word(rand64(), rand64(), 4'd3, 0));
		send_word(make_word(rand64(), rand64(), 4'd8, 1));
		settle();
		write_reg(bpdp_pkg::CFG_ACTIVE_PLANES, 4'd8);
		send_word(make_word('1, '1, 4'd8, 1));
		send_word(make_word('0, '1, 4'd8, 1));
		send_word(make_word('1, rand64(), 4'd5, 1));
		settle();
		// XOR: bytes past valid_bytes differ but must not count
		write_reg(bpdp_pkg::CFG_COMBINE_MODE, 4'd1);
		send_word(make_word('1, '0, 4'd2, 1));
		send_word(make_word(rand64(), rand64(), 4'd8, 0));
		send_word(make_word(rand64(), rand64(), 4'd1, 1));
		settle();
		write_reg(bpdp_pkg::CFG_ACTIVE_PLANES, 4'd0);
		send_word(make_word(rand64(), rand64(), 4'd8, 1));
		settle();
		write_reg(bpdp_pkg::CFG_ACTIVE_PLANES, 4'd15);
		send_word(make_word(rand64(), rand64(), 4'd8, 1));
		send_word(make_word('1, '0, 4'd8, 1));
		settle();

		for (int p = 0; p < 8; p++) begin
			if (p == 7) begin
				write_reg(bpdp_pkg::CFG_ACTIVE_PLANES, 4'($urandom_range(0, 15)));
				write_reg(bpdp_pkg::CFG_COMBINE_MODE, 4'($urandom_range(0, 1)));
			end else begin
				write_reg(bpdp_pkg::CFG_ACTIVE_PLANES, 4'(plane_pick[p]));
				write_reg(bpdp_pkg::CFG_COMBINE_MODE, 4'(mode_pick[p]));
			end
			quiet = (p == 1);
			if (p == 3) hold_due = 1;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if ($urandom_range(0, 99) < 15) begin
					send_vector($urandom_range(1, 6), 1);
				end else begin
					send_vector($urandom_range(1, 12), 0);
				end
			end
			settle();
		end

		if (tracker.totals_due.size() != 0) tracker.mismatches++;
		if (tracker.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
